// ===== rtl/core/linear_block_code_codec_unit_macros.svh =====
// Assertion macros shared by the codec RTL.
`ifndef LINEAR_BLOCK_CODE_CODEC_UNIT_MACROS_SVH
`define LINEAR_BLOCK_CODE_CODEC_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LBC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbc implication check failed");

`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbc next-cycle check failed");

`else

`define LBC_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/lbc_pkg.sv =====
package lbc_pkg;

   localparam int MSG_W  = 8;
   localparam int WORD_W = 16;
   localparam int SYND_W = 8;
   localparam int CNT_W  = 5;
   localparam int BITS_W = 4;
   localparam int CSR_W  = 64;
   localparam int IDX_W  = 2;

   localparam logic [IDX_W-1:0] CSR_MSG_BITS      = 2'd0;
   localparam logic [IDX_W-1:0] CSR_PARITY_BITS   = 2'd1;
   localparam logic [IDX_W-1:0] CSR_PARITY_MATRIX = 2'd2;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   typedef struct packed {
      logic [BITS_W-1:0] k;
      logic [BITS_W-1:0] q;
      logic [CSR_W-1:0]  matrix;
   } code_cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [CNT_W-1:0]  weight;
   } enc_result_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [SYND_W-1:0] syndrome;
      logic              found;
      logic [CNT_W-1:0]  position;
      logic              uncorrectable;
   } dec_result_type;

endpackage

// ===== rtl/core/lbc_encoder.sv =====
module lbc_encoder (
   input  lbc_pkg::code_cfg_type            cfg,
   input  logic [lbc_pkg::MSG_W-1:0]        message_word,
   output lbc_pkg::enc_result_type          result
);

   logic [lbc_pkg::MSG_W-1:0]  msg;
   logic [lbc_pkg::SYND_W-1:0] par;
   logic [lbc_pkg::WORD_W-1:0] word;

   always_comb begin
      for (int j = 0; j < lbc_pkg::MSG_W; j++) begin
         msg[j] = message_word[j] & (4'(j) < cfg.k);
      end
      for (int i = 0; i < lbc_pkg::SYND_W; i++) begin
         par[i] = (4'(i) < cfg.q) & (^(msg & cfg.matrix[lbc_pkg::MSG_W*i +: lbc_pkg::MSG_W]));
      end
      word = {8'b0, msg} | ({8'b0, par} << cfg.k);
   end

   assign result.word   = word;
   assign result.weight = lbc_pkg::CNT_W'($countones(word));

endmodule

// ===== rtl/core/lbc_decoder.sv =====
module lbc_decoder (
   input  lbc_pkg::code_cfg_type            cfg,
   input  logic [lbc_pkg::WORD_W-1:0]       received_word,
   output lbc_pkg::dec_result_type          result
);

   logic [lbc_pkg::CNT_W-1:0]  n;
   logic [lbc_pkg::SYND_W-1:0] qmask;
   logic [lbc_pkg::SYND_W-1:0] pcol [lbc_pkg::MSG_W];
   logic [lbc_pkg::SYND_W-1:0] hcol [lbc_pkg::WORD_W];
   logic [lbc_pkg::WORD_W-1:0] word;
   logic [lbc_pkg::SYND_W-1:0] synd;
   logic [3:0]                 pos;
   logic                       hit;

   assign n = {1'b0, cfg.k} + {1'b0, cfg.q};

   always_comb begin
      for (int p = 0; p < lbc_pkg::SYND_W; p++) begin
         qmask[p] = (4'(p) < cfg.q);
      end
      for (int j = 0; j < lbc_pkg::MSG_W; j++) begin
         for (int p = 0; p < lbc_pkg::SYND_W; p++) begin
            pcol[j][p] = cfg.matrix[lbc_pkg::MSG_W*p + j];
         end
      end
      for (int i = 0; i < lbc_pkg::WORD_W; i++) begin
         word[i] = received_word[i] & (5'(i) < n);
         if (5'(i) < {1'b0, cfg.k}) begin
            hcol[i] = pcol[3'(i)] & qmask;
         end else if (5'(i) < n) begin
            hcol[i] = 8'd1 << (5'(i) - {1'b0, cfg.k});
         end else begin
            hcol[i] = '0;
         end
      end
      synd = '0;
      for (int i = 0; i < lbc_pkg::WORD_W; i++) begin
         synd = synd ^ (hcol[i] & {lbc_pkg::SYND_W{word[i]}});
      end
      pos = '0;
      hit = 1'b0;
      for (int i = lbc_pkg::WORD_W - 1; i >= 0; i--) begin
         if ((5'(i) < n) && (hcol[i] == synd)) begin
            pos = 4'(i);
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      result.word          = word;
      result.syndrome      = synd;
      result.found         = (synd != '0);
      result.position      = '0;
      result.uncorrectable = 1'b0;
      if (synd != '0) begin
         if (hit) begin
            result.word     = word ^ (16'd1 << pos);
            result.position = {1'b0, pos} + 5'd1;
         end else begin
            result.uncorrectable = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/linear_block_code_codec_unit.sv =====
// Channel   Ports                                        Handshake
// request   req_command, req_message_word,               start & !busy
//           req_received_word
// response  rsp_code_word, rsp_code_weight, rsp_syndrome, rsp_valid, one cycle
//           rsp_error_found, rsp_error_position,
//           rsp_uncorrectable
// config    csr_index, csr_wdata                         csr_we
//
// One item per cycle, back to back. Accepting an item loads the input register;
// the response register then captures the result (XOR trees and column
// compares sit between), and rsp_valid is registered alongside it.
// busy is high during reset and in the first cycle after it; afterwards every
// start is taken.
// Synchronous reset restores k = 4, q = 3, matrix zero and clears valid flags.
// The receiver cannot stall: rsp_valid marks each item for one cycle.
`include "linear_block_code_codec_unit_macros.svh"

module linear_block_code_codec_unit #(
   parameter int MAX_MSG_BITS    = 8,
   parameter int MAX_PARITY_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [lbc_pkg::MSG_W-1:0]         req_message_word,
   input  logic [lbc_pkg::WORD_W-1:0]        req_received_word,
   output logic                              rsp_valid,
   output logic [lbc_pkg::WORD_W-1:0]        rsp_code_word,
   output logic [lbc_pkg::CNT_W-1:0]         rsp_code_weight,
   output logic [lbc_pkg::SYND_W-1:0]        rsp_syndrome,
   output logic                              rsp_error_found,
   output logic [lbc_pkg::CNT_W-1:0]         rsp_error_position,
   output logic                              rsp_uncorrectable,
   input  logic                              csr_we,
   input  logic [lbc_pkg::IDX_W-1:0]         csr_index,
   input  logic [lbc_pkg::CSR_W-1:0]         csr_wdata
);

   localparam logic [lbc_pkg::BITS_W-1:0] K_LIM =
      lbc_pkg::BITS_W'((MAX_MSG_BITS < lbc_pkg::MSG_W) ? MAX_MSG_BITS : lbc_pkg::MSG_W);
   localparam logic [lbc_pkg::BITS_W-1:0] Q_LIM =
      lbc_pkg::BITS_W'((MAX_PARITY_BITS < lbc_pkg::SYND_W) ? MAX_PARITY_BITS : lbc_pkg::SYND_W);

   logic [lbc_pkg::BITS_W-1:0] msg_bits_ff;
   logic [lbc_pkg::BITS_W-1:0] parity_bits_ff;
   logic [lbc_pkg::CSR_W-1:0]  parity_matrix_ff;
   logic                       busy_ff;

   logic                       req_valid_ff;
   logic                       req_valid_in;
   logic                       req_command_ff;
   logic [lbc_pkg::MSG_W-1:0]  req_message_ff;
   logic [lbc_pkg::WORD_W-1:0] req_received_ff;

   logic                       rsp_valid_ff;
   logic [lbc_pkg::WORD_W-1:0] rsp_word_ff;
   logic [lbc_pkg::WORD_W-1:0] rsp_word_in;
   logic [lbc_pkg::CNT_W-1:0]  rsp_weight_ff;
   logic [lbc_pkg::CNT_W-1:0]  rsp_weight_in;
   logic [lbc_pkg::SYND_W-1:0] rsp_synd_ff;
   logic [lbc_pkg::SYND_W-1:0] rsp_synd_in;
   logic                       rsp_found_ff;
   logic                       rsp_found_in;
   logic [lbc_pkg::CNT_W-1:0]  rsp_pos_ff;
   logic [lbc_pkg::CNT_W-1:0]  rsp_pos_in;
   logic                       rsp_unc_ff;
   logic                       rsp_unc_in;

   lbc_pkg::code_cfg_type      cfg;
   lbc_pkg::enc_result_type    enc_result;
   lbc_pkg::dec_result_type    dec_result;

   always_comb begin
      cfg.matrix = parity_matrix_ff;
      if (msg_bits_ff == '0) begin
         cfg.k = 4'd1;
      end else if (msg_bits_ff > K_LIM) begin
         cfg.k = K_LIM;
      end else begin
         cfg.k = msg_bits_ff;
      end
      if (parity_bits_ff == '0) begin
         cfg.q = 4'd1;
      end else if (parity_bits_ff > Q_LIM) begin
         cfg.q = Q_LIM;
      end else begin
         cfg.q = parity_bits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_bits_ff      <= 4'd4;
         parity_bits_ff   <= 4'd3;
         parity_matrix_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            lbc_pkg::CSR_MSG_BITS:      msg_bits_ff      <= csr_wdata[lbc_pkg::BITS_W-1:0];
            lbc_pkg::CSR_PARITY_BITS:   parity_bits_ff   <= csr_wdata[lbc_pkg::BITS_W-1:0];
            lbc_pkg::CSR_PARITY_MATRIX: parity_matrix_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy         = busy_ff;
   assign req_valid_in = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_command_ff  <= req_command;
         req_message_ff  <= req_message_word;
         req_received_ff <= req_received_word;
      end
   end

   lbc_encoder u_encoder (
      .cfg          (cfg),
      .message_word (req_message_ff),
      .result       (enc_result)
   );

   lbc_decoder u_decoder (
      .cfg           (cfg),
      .received_word (req_received_ff),
      .result        (dec_result)
   );

   always_comb begin
      if (req_command_ff == lbc_pkg::CMD_DECODE) begin
         rsp_word_in   = dec_result.word;
         rsp_weight_in = '0;
         rsp_synd_in   = dec_result.syndrome;
         rsp_found_in  = dec_result.found;
         rsp_pos_in    = dec_result.position;
         rsp_unc_in    = dec_result.uncorrectable;
      end else begin
         rsp_word_in   = enc_result.word;
         rsp_weight_in = enc_result.weight;
         rsp_synd_in   = '0;
         rsp_found_in  = 1'b0;
         rsp_pos_in    = '0;
         rsp_unc_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_word_ff   <= rsp_word_in;
         rsp_weight_ff <= rsp_weight_in;
         rsp_synd_ff   <= rsp_synd_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_unc_ff    <= rsp_unc_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_code_word      = rsp_word_ff;
   assign rsp_code_weight    = rsp_weight_ff;
   assign rsp_syndrome       = rsp_synd_ff;
   assign rsp_error_found    = rsp_found_ff;
   assign rsp_error_position = rsp_pos_ff;
   assign rsp_uncorrectable  = rsp_unc_ff;

   `LBC_ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_valid_ff, rsp_valid)
   `LBC_ASSERT_IMPLY(a_found_has_synd, clock, reset,
      rsp_valid && rsp_error_found, rsp_syndrome != '0)
   `LBC_ASSERT_IMPLY(a_unc_no_position, clock, reset,
      rsp_valid && rsp_uncorrectable, rsp_error_found && (rsp_error_position == '0))
   `LBC_ASSERT_IMPLY(a_clean_no_fix, clock, reset,
      rsp_valid && !rsp_error_found, (rsp_error_position == '0) && !rsp_uncorrectable)
   `LBC_ASSERT_IMPLY(a_weight_encode_only, clock, reset,
      rsp_valid && (rsp_code_weight != '0), rsp_syndrome == '0)

endmodule
